### sv/assert_macros.svh
// Assertion macros shared by the RTL of the waypoint drive controller.
// Depends on nothing; the including file supplies clock and reset names.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define WDD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define WDD_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define WDD_ASSERT(label, clk, rst_n, prop)
`define WDD_NEVER(label, clk, rst_n, cond)
`endif
`endif

### sv/wddpi_pkg.sv
// Package of the waypoint drive controller: widths, constants, register indexes.
// Depends on nothing.
`timescale 1ns / 1ps
package wddpi_pkg;
    localparam int GAIN_W = 20;
    localparam int DIST_W = 24;
    localparam int ANGLE_W = 15;
    localparam int PWM_W = 10;
    localparam int CFG_IDX_W = 2;
    localparam int MUL_A_W = 36;
    localparam int MUL_B_W = 24;
    localparam int PROD_W = MUL_A_W + MUL_B_W;
    localparam int ACC_W = 46;
    localparam int SPEED_W = 14;
    localparam int DINT_W = 15;
    localparam int HINT_W = 14;
    localparam int AERR_W = 14;
    localparam int HALF_W = 31;
    localparam int TURN_W = 48;
    localparam int MARGIN_W = 28;
    localparam int QUOT_IN_W = 17;
    localparam int CALC_W = 50;

    localparam logic [CFG_IDX_W-1:0] REG_DIST_P = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIST_I = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_P = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_I = 2'd3;

    localparam logic [GAIN_W-1:0] DIST_P_RESET = 20'd419430;
    localparam logic [GAIN_W-1:0] DIST_I_RESET = 20'd1049;
    localparam logic [GAIN_W-1:0] TURN_P_RESET = 20'd36700;
    localparam logic [GAIN_W-1:0] TURN_I_RESET = 20'd5243;

    localparam logic [SPEED_W-1:0] SPEED_MAX = 14'd13926;
    localparam logic [SPEED_W-1:0] SPEED_MIN = 14'd4915;
    localparam logic [SPEED_W-1:0] ARRIVE_SPEED = 14'd5734;
    localparam logic [DINT_W-1:0] DIST_INT_CAP = 15'd25600;
    localparam logic [HINT_W-1:0] TURN_INT_CAP = 14'd9600;
    localparam logic signed [16:0] HALF_CIRCLE = 17'sd11520;
    localparam logic signed [16:0] FULL_CIRCLE = 17'sd23040;
    localparam logic [AERR_W-1:0] STRAIGHT_BAND = 14'd192;

    localparam logic [MUL_B_W-1:0] HALF_K = 24'd100000;
    localparam logic [MUL_B_W-1:0] RAD_K = 24'd366022;
    localparam logic [MUL_B_W-1:0] TURN_K = 24'd50000;
    localparam logic [MUL_B_W-1:0] MARGIN_LEFT_K = 24'd15250;
    localparam logic [MUL_B_W-1:0] MARGIN_RIGHT_K = 24'd15860;
    localparam logic [MUL_B_W-1:0] FLOOR_K = 24'd111020;
    localparam logic [MUL_B_W-1:0] RECIP_122 = 24'd137519;
    localparam int RECIP_SHIFT = 24;
    localparam int PWM_FRAC = 14;
    localparam logic [CALC_W-1:0] FAST_LIMIT = 50'd1998848000;

    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_STRAIGHT = 2'd1;
    localparam logic [1:0] DIR_LEFT = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;
endpackage

### sv/wddpi_cfg_if.sv
// Configuration write channel of the waypoint drive controller.
// Depends on wddpi_pkg.
`timescale 1ns / 1ps
interface wddpi_cfg_if import wddpi_pkg::*; ();
    logic valid;
    logic ready;
    logic [CFG_IDX_W-1:0] index;
    logic [GAIN_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### sv/wddpi_tick_if.sv
// Control tick channel: distance, bearing, heading and the go and stop flags.
// Depends on wddpi_pkg.
`timescale 1ns / 1ps
interface wddpi_tick_if import wddpi_pkg::*; ();
    logic valid;
    logic ready;
    logic [DIST_W-1:0] target_distance;
    logic [ANGLE_W-1:0] target_bearing;
    logic [ANGLE_W-1:0] current_heading;
    logic target_active;
    logic stop_request;
    modport source (output valid, output target_distance, output target_bearing,
                    output current_heading, output target_active, output stop_request,
                    input ready);
    modport sink (input valid, input target_distance, input target_bearing,
                  input current_heading, input target_active, input stop_request,
                  output ready);
endinterface

### sv/wddpi_drive_if.sv
// Drive result channel: PWM compare values, direction and status flags.
// Depends on wddpi_pkg.
`timescale 1ns / 1ps
interface wddpi_drive_if import wddpi_pkg::*; ();
    logic valid;
    logic ready;
    logic [PWM_W-1:0] left_pwm;
    logic [PWM_W-1:0] right_pwm;
    logic drive_update;
    logic [1:0] direction;
    logic target_cleared;
    logic stop_acknowledged;
    modport source (output valid, output left_pwm, output right_pwm, output drive_update,
                    output direction, output target_cleared, output stop_acknowledged,
                    input ready);
    modport sink (input valid, input left_pwm, input right_pwm, input drive_update,
                  input direction, input target_cleared, input stop_acknowledged,
                  output ready);
endinterface

### sv/waypoint_differential_drive_pi.sv
// Waypoint PI drive controller. An active tick is worked through on one shared 36 x 24
// multiplier stepped by a sequencer, then one beat is offered; the next tick is taken
// once that beat has left, so no new tick is taken while one is in work or waiting.
// An idle or stop tick gives its beat in the cycle after it is taken.
// Reset loads the default gains and clears both integrals and the last speed.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module waypoint_differential_drive_pi import wddpi_pkg::*; #(
    parameter int GAIN_FRAC_BITS = 20
) (
    input logic clk,
    input logic rst_n,
    wddpi_cfg_if.sink cfg,
    wddpi_tick_if.sink tick,
    wddpi_drive_if.source drive
);
    localparam int SPEED_SHIFT = GAIN_FRAC_BITS - 6;
    localparam int RATE_SHIFT = GAIN_FRAC_BITS + 12;

    localparam logic [4:0] ST_SPD_P = 5'd0;
    localparam logic [4:0] ST_SPD_I = 5'd1;
    localparam logic [4:0] ST_TRN_P = 5'd2;
    localparam logic [4:0] ST_TRN_I = 5'd3;
    localparam logic [4:0] ST_HALF = 5'd4;
    localparam logic [4:0] ST_RATE = 5'd5;
    localparam logic [4:0] ST_POW2 = 5'd6;
    localparam logic [4:0] ST_TURN = 5'd7;
    localparam logic [4:0] ST_POW3 = 5'd8;
    localparam logic [4:0] ST_MARGIN = 5'd9;
    localparam logic [4:0] ST_POW4 = 5'd10;
    localparam logic [4:0] ST_WAIT4 = 5'd11;
    localparam logic [4:0] ST_POW5 = 5'd12;
    localparam logic [4:0] ST_WAIT5 = 5'd13;
    localparam logic [4:0] ST_FLOOR = 5'd14;
    localparam logic [4:0] ST_SLOW = 5'd15;
    localparam logic [4:0] ST_DIVF = 5'd16;
    localparam logic [4:0] ST_DIVS = 5'd17;
    localparam logic [4:0] ST_DONE = 5'd18;

    logic [GAIN_W-1:0] kp_reg, ki_reg, kt_reg, kti_reg;
    logic busy_reg;
    logic [4:0] step_reg;
    logic [DIST_W-1:0] dist_reg;
    logic [AERR_W-1:0] ae_reg;
    logic neg_reg, straight_reg;
    logic [DINT_W-1:0] di_reg;
    logic [HINT_W-1:0] j_reg;
    logic [SPEED_W-1:0] v_reg, p_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [HALF_W-1:0] half_reg;
    logic [MUL_A_W-1:0] wq_reg;
    logic [TURN_W-1:0] turn_reg;
    logic [MARGIN_W-1:0] margin_reg;
    logic [QUOT_IN_W-1:0] fastn_reg, slown_reg;
    logic [PWM_W-1:0] fastq_reg;

    logic out_valid_reg;
    logic [PWM_W-1:0] left_reg, right_reg;
    logic update_reg, cleared_reg, ack_reg;
    logic [1:0] dir_reg;

    logic tick_fire, drive_fire;
    logic signed [16:0] e_raw, e_wrap;
    logic [AERR_W-1:0] ae_in;
    logic [DINT_W:0] di_sum;
    logic [HINT_W:0] j_sum;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [ACC_W-1:0] spd_sum, spd_shift;
    logic [SPEED_W-1:0] spd_clamp;
    logic [CALC_W-1:0] hpt, hpm, fast_min, fast_val, fast_sel;
    logic signed [CALC_W-1:0] hmt, hmm, slow_min, slow_val, floor_val;
    logic arrived;
    logic [PWM_W-1:0] slowq;

    assign cfg.ready = 1'b1;
    assign tick.ready = !busy_reg && !out_valid_reg;
    assign tick_fire = tick.valid && tick.ready;
    assign drive_fire = drive.valid && drive.ready;

    assign drive.valid = out_valid_reg;
    assign drive.left_pwm = left_reg;
    assign drive.right_pwm = right_reg;
    assign drive.drive_update = update_reg;
    assign drive.direction = dir_reg;
    assign drive.target_cleared = cleared_reg;
    assign drive.stop_acknowledged = ack_reg;

    always_comb
    begin
        e_raw = signed'({2'b00, tick.target_bearing}) - signed'({2'b00, tick.current_heading});
        if (e_raw > HALF_CIRCLE)
        begin
            e_wrap = e_raw - FULL_CIRCLE;
        end
        else if (e_raw < -HALF_CIRCLE)
        begin
            e_wrap = e_raw + FULL_CIRCLE;
        end
        else
        begin
            e_wrap = e_raw;
        end
        ae_in = e_wrap[16] ? AERR_W'(-e_wrap) : AERR_W'(e_wrap);
        di_sum = {1'b0, di_reg} + (DINT_W+1)'(tick.target_distance);
        if (tick.target_distance > DIST_W'(DIST_INT_CAP) || di_sum > (DINT_W+1)'(DIST_INT_CAP))
        begin
            di_sum = (DINT_W+1)'(DIST_INT_CAP);
        end
        j_sum = {1'b0, j_reg} + {1'b0, ae_reg};
        if (j_sum > (HINT_W+1)'(TURN_INT_CAP))
        begin
            j_sum = (HINT_W+1)'(TURN_INT_CAP);
        end
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (step_reg)
            ST_SPD_P:
            begin
                mul_a = MUL_A_W'(dist_reg);
                mul_b = MUL_B_W'(kp_reg);
            end
            ST_SPD_I:
            begin
                mul_a = MUL_A_W'(di_reg);
                mul_b = MUL_B_W'(ki_reg);
            end
            ST_TRN_P:
            begin
                mul_a = MUL_A_W'(ae_reg);
                mul_b = MUL_B_W'(kt_reg);
            end
            ST_TRN_I:
            begin
                mul_a = MUL_A_W'(j_reg);
                mul_b = MUL_B_W'(kti_reg);
            end
            ST_HALF:
            begin
                mul_a = MUL_A_W'(v_reg);
                mul_b = HALF_K;
            end
            ST_RATE:
            begin
                mul_a = acc_reg[MUL_A_W-1:0];
                mul_b = RAD_K;
            end
            ST_POW2, ST_POW3, ST_POW4, ST_POW5:
            begin
                mul_a = MUL_A_W'(p_reg);
                mul_b = MUL_B_W'(v_reg);
            end
            ST_TURN:
            begin
                mul_a = wq_reg;
                mul_b = TURN_K;
            end
            ST_MARGIN:
            begin
                mul_a = MUL_A_W'(v_reg);
                mul_b = neg_reg ? MARGIN_LEFT_K : MARGIN_RIGHT_K;
            end
            ST_FLOOR:
            begin
                mul_a = MUL_A_W'(p_reg);
                mul_b = FLOOR_K;
            end
            ST_DIVF:
            begin
                mul_a = MUL_A_W'(fastn_reg);
                mul_b = RECIP_122;
            end
            ST_DIVS:
            begin
                mul_a = MUL_A_W'(slown_reg);
                mul_b = RECIP_122;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        spd_sum = acc_reg + ACC_W'(prod_reg);
        spd_shift = spd_sum >> SPEED_SHIFT;
        if (spd_shift > ACC_W'(SPEED_MAX))
        begin
            spd_clamp = SPEED_MAX;
        end
        else if (spd_shift < ACC_W'(SPEED_MIN))
        begin
            spd_clamp = SPEED_MIN;
        end
        else
        begin
            spd_clamp = spd_shift[SPEED_W-1:0];
        end
        hpt = CALC_W'(half_reg) + CALC_W'(turn_reg);
        hpm = CALC_W'(half_reg) + CALC_W'(margin_reg);
        fast_min = (hpt < FAST_LIMIT) ? hpt : FAST_LIMIT;
        fast_val = (fast_min > hpm) ? fast_min : hpm;
        fast_sel = straight_reg ? CALC_W'(half_reg) : fast_val;
        hmt = signed'(CALC_W'(half_reg)) - signed'(CALC_W'(turn_reg));
        hmm = signed'(CALC_W'(half_reg)) - signed'(CALC_W'(margin_reg));
        floor_val = signed'(CALC_W'(prod_reg[HALF_W-1:0]));
        slow_min = (hmt < hmm) ? hmt : hmm;
        slow_val = (slow_min > floor_val) ? slow_min : floor_val;
        arrived = v_reg <= ARRIVE_SPEED;
        slowq = PWM_W'(prod_reg >> RECIP_SHIFT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg <= DIST_P_RESET;
            ki_reg <= DIST_I_RESET;
            kt_reg <= TURN_P_RESET;
            kti_reg <= TURN_I_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_DIST_P: kp_reg <= cfg.data;
                REG_DIST_I: ki_reg <= cfg.data;
                REG_TURN_P: kt_reg <= cfg.data;
                REG_TURN_I: kti_reg <= cfg.data;
                default: kp_reg <= kp_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= ST_SPD_P;
            out_valid_reg <= 1'b0;
            di_reg <= '0;
            j_reg <= '0;
            v_reg <= '0;
        end
        else
        begin
            if (drive_fire)
            begin
                out_valid_reg <= 1'b0;
            end
            if (tick_fire)
            begin
                if (tick.target_active && !tick.stop_request)
                begin
                    busy_reg <= 1'b1;
                    step_reg <= ST_SPD_P;
                    di_reg <= di_sum[DINT_W-1:0];
                end
                else
                begin
                    out_valid_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 5'd1;
                if (step_reg == ST_SPD_P)
                begin
                    j_reg <= j_sum[HINT_W-1:0];
                end
                if (step_reg == ST_TRN_P)
                begin
                    v_reg <= spd_clamp;
                end
                if (step_reg == ST_DONE)
                begin
                    busy_reg <= 1'b0;
                    out_valid_reg <= 1'b1;
                    if (straight_reg)
                    begin
                        j_reg <= '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        if (tick_fire)
        begin
            dist_reg <= tick.target_distance;
            ae_reg <= ae_in;
            neg_reg <= e_wrap[16];
            straight_reg <= ae_in <= STRAIGHT_BAND;
            left_reg <= '0;
            right_reg <= '0;
            update_reg <= 1'b0;
            dir_reg <= DIR_STOP;
            cleared_reg <= arrived || tick.stop_request;
            ack_reg <= tick.stop_request;
        end
        else if (busy_reg)
        begin
            case (step_reg)
                ST_SPD_I: acc_reg <= ACC_W'(prod_reg);
                ST_TRN_P: p_reg <= spd_clamp;
                ST_TRN_I: acc_reg <= ACC_W'(prod_reg);
                ST_HALF: acc_reg <= spd_sum;
                ST_RATE: half_reg <= prod_reg[HALF_W-1:0];
                ST_POW2: wq_reg <= MUL_A_W'(prod_reg >> RATE_SHIFT);
                ST_TURN, ST_MARGIN, ST_WAIT4, ST_WAIT5: p_reg <= prod_reg[2*SPEED_W-1:SPEED_W];
                ST_POW3: turn_reg <= prod_reg[TURN_W-1:0];
                ST_POW4: margin_reg <= prod_reg[MARGIN_W-1:0];
                ST_FLOOR: fastn_reg <= fast_sel[PWM_FRAC +: QUOT_IN_W];
                ST_SLOW: slown_reg <= slow_val[PWM_FRAC +: QUOT_IN_W];
                ST_DIVS: fastq_reg <= PWM_W'(prod_reg >> RECIP_SHIFT);
                ST_DONE:
                begin
                    update_reg <= 1'b1;
                    cleared_reg <= arrived;
                    if (straight_reg)
                    begin
                        left_reg <= fastq_reg;
                        right_reg <= fastq_reg;
                        dir_reg <= arrived ? DIR_STOP : DIR_STRAIGHT;
                    end
                    else if (neg_reg)
                    begin
                        right_reg <= fastq_reg;
                        left_reg <= slowq;
                        dir_reg <= arrived ? DIR_STOP : DIR_LEFT;
                    end
                    else
                    begin
                        left_reg <= fastq_reg;
                        right_reg <= slowq;
                        dir_reg <= arrived ? DIR_STOP : DIR_RIGHT;
                    end
                end
                default: acc_reg <= acc_reg;
            endcase
        end
    end

    `WDD_NEVER(a_busy_and_beat, clk, rst_n, busy_reg && out_valid_reg)
    `WDD_NEVER(a_integral_caps, clk, rst_n, di_reg > DIST_INT_CAP || j_reg > TURN_INT_CAP)
    `WDD_ASSERT(a_drive_speed, clk, rst_n, (out_valid_reg && update_reg) |-> (v_reg >= SPEED_MIN && v_reg <= SPEED_MAX))
    `WDD_ASSERT(a_tick_starts, clk, rst_n, tick_fire |=> (busy_reg || out_valid_reg))
endmodule
